@@ rtl/core/bpc_pkg.sv @@
// types, constants and codes shared by the button press classifier
// no dependencies
package bpc_pkg;

    // number of buttons handled side by side
    localparam int BUTTON_COUNT = 8;
    localparam int BTN_IDX_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    // most results one tick may report
    localparam int MAX_RESULTS  = 8;
    localparam int CNT_W        = $clog2(MAX_RESULTS);

    // configuration port
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam logic REG_LONG   = 1'b0;
    localparam logic REG_NORMAL = 1'b1;
    localparam logic [15:0] LONG_RESET   = 16'd1000;
    localparam logic [15:0] NORMAL_RESET = 16'd50;

    // request opcodes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_ATTACH = 1'b1;

    // per-button phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_WAIT    = 2'd2,
        PH_NONE    = 2'd3
    } t_phase;

    // result kinds
    typedef enum logic [2:0] {
        EV_DOWN   = 3'd0,
        EV_NORMAL = 3'd1,
        EV_LONG   = 3'd2,
        EV_UP     = 3'd3,
        EV_ATTACH = 3'd4
    } t_event;

    // input request
    typedef struct packed {
        logic        opcode;
        logic [2:0]  button_index;
        logic        attach_enable;
        logic [7:0]  pressed_bits;
        logic [31:0] now_ms;
    } t_in_req;

    // result request
    typedef struct packed {
        logic [2:0] button_id;
        t_event     event_kind;
        logic       held_at_attach;
        logic       last;
    } t_out_req;

    // what one lane found on a tick
    typedef struct packed {
        logic   hit;
        t_event kind;
    } t_lane_evt;

endpackage

@@ rtl/core/bpc_lane.sv @@
// one button's phase machine, stepped once per tick request
// depends on bpc_pkg
module bpc_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic               i_attach,
    input  logic               i_attach_en,
    input  logic               i_held,
    input  logic [31:0]        i_now_ms,
    input  logic [15:0]        i_long_ms,
    input  logic [15:0]        i_normal_ms,
    output bpc_pkg::t_lane_evt o_evt
);
    import bpc_pkg::*;

    logic        r_enabled, n_enabled;
    t_phase      r_now, n_now;
    t_phase      r_before, n_before;
    t_phase      r_next, n_next;
    logic [31:0] r_start, n_start;
    logic [31:0] elapsed;

    // time held since the press started, wrapping
    assign elapsed = i_now_ms - r_start;

    // next state and event of this button
    always_comb begin
        n_enabled = r_enabled;
        n_now     = r_now;
        n_before  = r_before;
        n_next    = r_next;
        n_start   = r_start;
        o_evt     = '{hit: 1'b0, kind: EV_DOWN};
        if (i_attach) begin
            n_enabled = i_attach_en;
            n_before  = PH_NONE;
            n_now     = i_held ? PH_WAIT : PH_IDLE;
            n_next    = i_held ? PH_WAIT : PH_IDLE;
        end else if (i_tick && r_enabled && (r_now != PH_NONE)) begin
            if (r_now != r_before) begin
                // entry action
                if (r_now == PH_PRESSED) begin
                    n_start = i_now_ms;
                    o_evt   = '{hit: 1'b1, kind: EV_DOWN};
                end
                n_before = r_now;
            end else if (r_next == r_now) begin
                // transition test
                case (r_now)
                    PH_IDLE: begin
                        if (i_held) n_next = PH_PRESSED;
                    end
                    PH_PRESSED: begin
                        if (i_held) begin
                            if (elapsed > {16'd0, i_long_ms}) begin
                                o_evt  = '{hit: 1'b1, kind: EV_LONG};
                                n_next = PH_WAIT;
                            end
                        end else begin
                            if (elapsed > {16'd0, i_normal_ms}) begin
                                o_evt = '{hit: 1'b1, kind: EV_NORMAL};
                            end
                            n_next = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                        if (!i_held) n_next = PH_IDLE;
                    end
                    default: begin
                        n_next = r_next;
                    end
                endcase
            end else begin
                // exit action
                if (r_now == PH_WAIT) begin
                    o_evt = '{hit: 1'b1, kind: EV_UP};
                end
                n_now = r_next;
            end
        end
    end

    // button state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_now     <= PH_IDLE;
            r_before  <= PH_IDLE;
            r_next    <= PH_IDLE;
            r_start   <= '0;
        end else begin
            r_enabled <= n_enabled;
            r_now     <= n_now;
            r_before  <= n_before;
            r_next    <= n_next;
            r_start   <= n_start;
        end
    end

endmodule

@@ rtl/core/bpc_merge.sv @@
// gathers the lanes' events and hands them out one result a cycle in button order unless stalled
// depends on bpc_pkg
module bpc_merge (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load_tick,
    input  logic                                     i_load_attach,
    input  bpc_pkg::t_lane_evt [bpc_pkg::BUTTON_COUNT-1:0] i_evts,
    input  logic [2:0]                               i_attach_id,
    input  logic                                     i_attach_held,
    input  logic                                     i_out_stall,
    output logic                                     o_out_valid,
    output bpc_pkg::t_out_req                        o_out,
    output logic                                     o_busy
);
    import bpc_pkg::*;

    logic [BUTTON_COUNT-1:0] r_pend, n_pend;
    t_event                  r_kind [BUTTON_COUNT];
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    t_out_req                r_out, n_out;

    logic [BUTTON_COUNT-1:0] pick;
    logic [BUTTON_COUNT-1:0] rest;
    logic [BTN_IDX_W-1:0]    pick_idx;
    logic                    slot_free;
    logic                    is_last;

    assign slot_free = !r_out_valid || !i_out_stall;

    // lowest pending button
    assign pick = r_pend & (~r_pend + 1'b1);
    assign rest = r_pend & ~pick;
    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (pick[i]) pick_idx = BTN_IDX_W'(i);
        end
    end

    // final result of the tick: nothing left, or the result limit reached
    assign is_last = (rest == '0) || (r_cnt == CNT_W'(MAX_RESULTS - 1));

    // output slot and pending set
    always_comb begin
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_load_attach) begin
            n_out_valid = 1'b1;
            n_out       = '{button_id: i_attach_id, event_kind: EV_ATTACH,
                            held_at_attach: i_attach_held, last: 1'b1};
        end else if (i_load_tick) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                n_pend[i] = i_evts[i].hit;
            end
            n_cnt = '0;
        end else if ((r_pend != '0) && slot_free) begin
            n_out_valid = 1'b1;
            n_out       = '{button_id: 3'(pick_idx), event_kind: r_kind[pick_idx],
                            held_at_attach: 1'b0, last: is_last};
            n_pend      = is_last ? '0 : rest;
            n_cnt       = r_cnt + 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // event kinds captured at the tick
    always_ff @(posedge i_clk) begin
        if (i_load_tick) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_kind[i] <= i_evts[i].kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_busy      = r_out_valid || (r_pend != '0);

    // a new request only lands on an empty merge stage
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load_tick || i_load_attach) |-> !o_busy)
        else $error("request loaded while results outstanding");

    // nothing stays pending once the final result is shown
    a_last_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_pend == '0))
        else $error("pending events behind a final result");

    // pending set only loses members between loads
    a_pend_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_load_tick |=> ((r_pend & ~$past(r_pend)) == '0))
        else $error("pending set grew without a tick");

    // an attach reply is always the only result
    a_attach_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_kind == EV_ATTACH)) |-> r_out.last)
        else $error("attach reply without last");

endmodule

@@ rtl/core/button_press_classifier_core.sv @@
// button press classifier: one lane per button, merged into a serial result stream
// attach reply shows in the cycle after the request; tick events pass through the pending set, then the output register
// a new request is held off while results are outstanding; the merge stage hands out one result a cycle
// unless the output stalls, and a tick that finds no events leaves it free for a new request
// synchronous active-low reset: thresholds 1000 and 50 ms, all buttons disabled and idle
module button_press_classifier_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bpc_pkg::t_in_req                i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bpc_pkg::t_out_req               o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]      paddr,
    input  logic [bpc_pkg::DATA_W-1:0]      pwdata,
    output logic [bpc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import bpc_pkg::*;

    logic [15:0] r_long_ms;
    logic [15:0] r_normal_ms;
    logic        busy;
    logic        accept;
    logic        do_tick;
    logic        do_attach;
    logic        cfg_wr;
    t_lane_evt [BUTTON_COUNT-1:0] lane_evts;

    // request handshake
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign do_tick    = accept && (i_in.opcode == OP_TICK);
    assign do_attach  = accept && (i_in.opcode == OP_ATTACH);

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms   <= LONG_RESET;
            r_normal_ms <= NORMAL_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LONG:   r_long_ms   <= pwdata[15:0];
                REG_NORMAL: r_normal_ms <= pwdata[15:0];
                default:    r_long_ms   <= r_long_ms;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            REG_LONG:   prdata = {16'd0, r_long_ms};
            REG_NORMAL: prdata = {16'd0, r_normal_ms};
            default:    prdata = '0;
        endcase
    end

    // one lane per button; buttons past the eighth read as released
    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
        logic held;
        if (g < 8) begin : g_in
            assign held = i_in.pressed_bits[g];
        end else begin : g_out
            assign held = 1'b0;
        end

        bpc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tick      (do_tick),
            .i_attach    (do_attach && (int'(i_in.button_index) == g)),
            .i_attach_en (i_in.attach_enable),
            .i_held      (held),
            .i_now_ms    (i_in.now_ms),
            .i_long_ms   (r_long_ms),
            .i_normal_ms (r_normal_ms),
            .o_evt       (lane_evts[g])
        );
    end

    // serialise the lanes' findings
    bpc_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load_tick   (do_tick),
        .i_load_attach (do_attach),
        .i_evts        (lane_evts),
        .i_attach_id   (i_in.button_index),
        .i_attach_held (i_in.pressed_bits[i_in.button_index]),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out         (o_out),
        .o_busy        (busy)
    );

endmodule
